>>> rtl/core/jrsi_pkg.sv
// Shared types and constants for the joystick rate servo integrator.
// Beat structures, field widths, mode codes and reset values of the joints.
// No dependencies.
package jrsi_pkg;

  localparam int JOINTS    = 4;
  localparam int STICK_W   = 8;
  localparam int RATE_W    = 8;
  localparam int LIMIT_W   = 12;
  localparam int CFG_IDX_W = 3;
  localparam int DEAD_ZONE = 4;

  typedef enum logic [1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_TICK   = 2'd1,
    MODE_ENABLE = 2'd2
  } mode_e;

  typedef struct packed {
    mode_e                     mode;
    logic signed [STICK_W-1:0] left_x;
    logic signed [STICK_W-1:0] left_y;
    logic signed [STICK_W-1:0] right_x;
    logic signed [STICK_W-1:0] right_y;
    logic                      enable_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [LIMIT_W-1:0] rotator_angle;
    logic signed [LIMIT_W-1:0] boom_angle;
    logic signed [LIMIT_W-1:0] grapple_angle;
    logic signed [LIMIT_W-1:0] forearm_angle;
  } out_beat_t;

  typedef struct packed {
    logic load_rate;
    logic step;
    logic wr_max;
    logic wr_min;
  } joint_ctrl_t;

  localparam logic signed [LIMIT_W-1:0] LIMIT_MAX_RST [JOINTS] =
    '{12'sd1100, 12'sd1080, 12'sd600, 12'sd500};
  localparam logic signed [LIMIT_W-1:0] LIMIT_MIN_RST [JOINTS] =
    '{-12'sd600, -12'sd200, -12'sd700, -12'sd1800};
  localparam logic signed [LIMIT_W-1:0] ANGLE_RST [JOINTS] =
    '{12'sd0, -12'sd200, -12'sd700, -12'sd1800};

endpackage

>>> rtl/core/jrsi_stick_map.sv
// Stick to joint rate mapping: halving, dead zone test and dominant axis pick.
// Purely combinational; depends on jrsi_pkg.
module jrsi_stick_map (
  input  jrsi_pkg::in_beat_t               sample,
  output logic signed [jrsi_pkg::RATE_W-1:0] rate [jrsi_pkg::JOINTS],
  output logic                             outside
);
  import jrsi_pkg::*;

  function automatic logic signed [RATE_W-1:0] halve(input logic signed [STICK_W-1:0] v);
    logic signed [STICK_W-1:0] t;
    begin
      // Adding the sign bit before the shift makes it round toward zero.
      t = v + STICK_W'({1'b0, v[STICK_W-1]});
      halve = RATE_W'(t >>> 1);
    end
  endfunction

  function automatic logic out_of_zone(input logic signed [RATE_W-1:0] v);
    out_of_zone = (v > RATE_W'(DEAD_ZONE)) || (v < -RATE_W'(DEAD_ZONE));
  endfunction

  function automatic logic [RATE_W-2:0] mag(input logic signed [RATE_W-1:0] v);
    logic signed [RATE_W-1:0] a;
    begin
      a = v[RATE_W-1] ? -v : v;
      mag = a[RATE_W-2:0];
    end
  endfunction

  logic signed [RATE_W-1:0] lx, ly, rx, ry;
  logic signed [RATE_W-1:0] d0;

  always_comb begin
    lx = halve(sample.left_x);
    ly = halve(sample.left_y);
    rx = halve(sample.right_x);
    ry = halve(sample.right_y);
    outside = out_of_zone(lx) || out_of_zone(ly) || out_of_zone(rx) || out_of_zone(ry);
    // The base rotation runs opposite to the left stick X axis.
    d0 = -lx;
    // Each stick drives its stronger axis only; a tie goes to the Y axis.
    if (mag(d0) > mag(ly)) begin
      rate[0] = d0;
      rate[1] = '0;
    end else begin
      rate[0] = '0;
      rate[1] = ly;
    end
    if (mag(rx) > mag(ry)) begin
      rate[2] = rx;
      rate[3] = '0;
    end else begin
      rate[2] = '0;
      rate[3] = ry;
    end
  end

endmodule

>>> rtl/core/jrsi_joint.sv
// One servo joint: rate, angle and limit registers with the add and clamp step.
// Depends on jrsi_pkg.
module jrsi_joint #(
  parameter int ANGLE_BITS = 12,
  parameter int JOINT      = 0
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  jrsi_pkg::joint_ctrl_t                 ctrl,
  input  logic signed [jrsi_pkg::RATE_W-1:0]    rate_in,
  input  logic signed [jrsi_pkg::LIMIT_W-1:0]   cfg_data,
  output logic signed [jrsi_pkg::LIMIT_W-1:0]   angle_next
);
  import jrsi_pkg::*;

  localparam int SW = ANGLE_BITS + 1;

  logic signed [ANGLE_BITS-1:0] angle;
  logic signed [RATE_W-1:0]     rate;
  logic signed [LIMIT_W-1:0]    lim_max;
  logic signed [LIMIT_W-1:0]    lim_min;

  logic signed [SW-1:0] sum, hi_x, lo_x, above, clamped;

  always_comb begin
    sum  = {angle[ANGLE_BITS-1], angle} + {{(SW-RATE_W){rate[RATE_W-1]}}, rate};
    hi_x = {{(SW-LIMIT_W){lim_max[LIMIT_W-1]}}, lim_max};
    lo_x = {{(SW-LIMIT_W){lim_min[LIMIT_W-1]}}, lim_min};
    // Maximum first, then minimum, so the minimum wins if the two cross.
    above   = (sum > hi_x) ? hi_x : sum;
    clamped = (above < lo_x) ? lo_x : above;
    angle_next = clamped[LIMIT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle   <= ANGLE_BITS'(ANGLE_RST[JOINT]);
      rate    <= '0;
      lim_max <= LIMIT_MAX_RST[JOINT];
      lim_min <= LIMIT_MIN_RST[JOINT];
    end else begin
      if (ctrl.step) angle <= clamped[ANGLE_BITS-1:0];
      if (ctrl.load_rate) rate <= rate_in;
      if (ctrl.wr_max) lim_max <= cfg_data;
      if (ctrl.wr_min) lim_min <= cfg_data;
    end
  end

endmodule

>>> rtl/core/joystick_rate_servo_integrator_unit.sv
// Joystick rate servo integrator, top level.
// A moving tick's result beat is loaded into the result register when the tick
// leaves the input stage, which waits while an older result beat is unaccepted.
// Throughput: one input beat per cycle; the single input stage only holds off
// while a tick that yields a result waits behind an unaccepted result beat.
// Reset (synchronous, active high) disables the arm, stops motion, clears the
// rates, restores the default limits and angles and empties both stages.
module joystick_rate_servo_integrator_unit #(
  parameter int ANGLE_BITS = 12
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  jrsi_pkg::in_beat_t                     in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output jrsi_pkg::out_beat_t                    out_data,
  input  logic                                   cfg_we,
  input  logic [jrsi_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic signed [jrsi_pkg::LIMIT_W-1:0]    cfg_data
);
  import jrsi_pkg::*;

  // Input stage: each accepted beat is held here until it is acted on.
  logic     s1_valid;
  in_beat_t s1_data;

  // Arm state shared by all joints.
  logic arm_enabled;
  logic moving;

  logic signed [RATE_W-1:0]  map_rate [JOINTS];
  logic                      map_outside;
  logic signed [LIMIT_W-1:0] angle_next [JOINTS];
  joint_ctrl_t               jctrl [JOINTS];

  logic tick_out;
  logic advance;

  // A tick while moving is the only beat that produces a result; it alone
  // needs room in the output register before it may leave the input stage.
  assign tick_out = s1_valid && (s1_data.mode == MODE_TICK) && moving;
  assign advance  = s1_valid && (!tick_out || !out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
  end

  jrsi_stick_map u_map (
    .sample  (s1_data),
    .rate    (map_rate),
    .outside (map_outside)
  );

  // Enable and motion flags change only when the held beat is acted on, so
  // the following beat always sees the state that this one leaves behind.
  always_ff @(posedge clk) begin
    if (rst) begin
      arm_enabled <= 1'b0;
      moving      <= 1'b0;
    end else if (advance) begin
      unique case (s1_data.mode)
        MODE_SAMPLE: begin
          if (arm_enabled) moving <= map_outside;
        end
        MODE_ENABLE: begin
          arm_enabled <= s1_data.enable_value;
          // Disabling stops motion; enabling leaves motion as it was.
          if (!s1_data.enable_value) moving <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar j = 0; j < JOINTS; j++) begin : g_joint
    always_comb begin
      jctrl[j].load_rate = advance && (s1_data.mode == MODE_SAMPLE) && arm_enabled
                           && map_outside;
      jctrl[j].step      = advance && tick_out;
      jctrl[j].wr_max    = cfg_we && (cfg_index == CFG_IDX_W'(2 * j));
      jctrl[j].wr_min    = cfg_we && (cfg_index == CFG_IDX_W'(2 * j + 1));
    end

    jrsi_joint #(
      .ANGLE_BITS (ANGLE_BITS),
      .JOINT      (j)
    ) u_joint (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (jctrl[j]),
      .rate_in    (map_rate[j]),
      .cfg_data   (cfg_data),
      .angle_next (angle_next[j])
    );
  end

  // Result register: loaded with the freshly clamped angles on a moving tick
  // and held until the downstream side takes the beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && tick_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance && tick_out) begin
      out_data.rotator_angle <= angle_next[0];
      out_data.boom_angle    <= angle_next[1];
      out_data.grapple_angle <= angle_next[2];
      out_data.forearm_angle <= angle_next[3];
    end
  end

endmodule

>>> rtl/core/jrsi_checker.sv
// Port-level checks for the joystick rate servo integrator, bound to the top.
// Depends on jrsi_pkg and joystick_rate_servo_integrator_unit.
module jrsi_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input jrsi_pkg::in_beat_t                  in_data,
  input logic                                out_valid,
  input logic                                out_ready,
  input jrsi_pkg::out_beat_t                 out_data,
  input logic                                cfg_we,
  input logic [jrsi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input logic signed [jrsi_pkg::LIMIT_W-1:0] cfg_data
);
  import jrsi_pkg::*;

  // A stalled result beat keeps its angles.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // The input side is only held off behind a stalled result.
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input held off without a stalled result");

  // Reset empties the block.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not empty after reset");

  // A new result follows an accepted tick beat.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && (in_data.mode == MODE_TICK), 2))
    else $error("result beat without a matching tick");

endmodule

bind joystick_rate_servo_integrator_unit jrsi_checker u_jrsi_checker (.*);
